### rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// Measurement record framer package
// Shared constants, source codes and the record header type.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int DEF_MAX_SLOTS    = 8;
    localparam int DEF_BUFFER_BYTES = 64;
    localparam int QUEUE_DEPTH      = 2;

    localparam int HDR_BYTES = 3;
    localparam int TS_BYTES  = 4;

    localparam logic [7:0]  POS_TYPE   = 8'd0;
    localparam logic [7:0]  POS_LEN    = 8'd1;
    localparam logic [7:0]  POS_TS0    = 8'd2;
    localparam logic [7:0]  POS_SLOT0  = 8'd6;
    localparam logic [7:0]  END_MARK   = 8'hFF;
    localparam logic [15:0] FILL_VALUE = 16'hFFFF;

    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_CHANNEL_MAP   = 2'd1;
    localparam logic [1:0] REG_RECORD_TYPE   = 2'd2;

    localparam logic [2:0] SRC_ADC0 = 3'd0;
    localparam logic [2:0] SRC_ADC1 = 3'd1;
    localparam logic [2:0] SRC_ADC2 = 3'd2;
    localparam logic [2:0] SRC_ADC3 = 3'd3;
    localparam logic [2:0] SRC_PINS = 3'd4;

    typedef struct packed {
        logic        drop;
        logic [7:0]  rtype;
        logic [7:0]  length;
        logic [31:0] ts;
    } t_rec_hdr;

endpackage

### rtl/mrf_front.sv
// ----------------------------------------------------------------------------
// Measurement record framer front end
// Classifies a request as fitting or dropped and builds its slot values.
// ----------------------------------------------------------------------------
module mrf_front import mrf_pkg::*; #(
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  logic [3:0]              i_channel_count,
    input  logic [23:0]             i_channel_map,
    input  logic [7:0]              i_record_type,
    input  logic [31:0]             i_timestamp_ms,
    input  logic [11:0]             i_adc_sample_0,
    input  logic [11:0]             i_adc_sample_1,
    input  logic [11:0]             i_adc_sample_2,
    input  logic [11:0]             i_adc_sample_3,
    input  logic [7:0]              i_port_pins,
    input  logic [6:0]              i_free_space,
    output t_rec_hdr                o_hdr,
    output logic [MAX_SLOTS*16-1:0] o_values
);

    localparam logic [3:0] MAX_CNT = 4'(MAX_SLOTS);
    localparam logic [7:0] BUF_MAX = 8'(BUFFER_BYTES);

    logic [3:0]  slots;
    logic [7:0]  content;
    logic [7:0]  total;
    logic [7:0]  space;
    logic [15:0] pins_val;

    always_comb begin
        slots    = (i_channel_count > MAX_CNT) ? MAX_CNT : i_channel_count;
        content  = 8'(TS_BYTES) + {3'd0, slots, 1'b0};
        total    = content + 8'(HDR_BYTES);
        space    = ({1'b0, i_free_space} > BUF_MAX) ? BUF_MAX : {1'b0, i_free_space};
        pins_val = {12'd0, i_port_pins[4:3], i_port_pins[1:0]};

        o_hdr.drop   = (space < total);
        o_hdr.rtype  = i_record_type;
        o_hdr.length = content;
        o_hdr.ts     = i_timestamp_ms;
    end

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_slot
        logic [2:0]  code;
        logic [15:0] val;
        always_comb begin
            code = i_channel_map[3*g +: 3];
            unique case (code)
                SRC_ADC0: val = {4'd0, i_adc_sample_0};
                SRC_ADC1: val = {4'd0, i_adc_sample_1};
                SRC_ADC2: val = {4'd0, i_adc_sample_2};
                SRC_ADC3: val = {4'd0, i_adc_sample_3};
                SRC_PINS: val = pins_val;
                default:  val = FILL_VALUE;
            endcase
        end
        assign o_values[16*g +: 16] = val | {i_timestamp_ms[3:0], 12'd0};
    end

endmodule

### rtl/mrf_queue.sv
// ----------------------------------------------------------------------------
// Measurement record framer queue
// Short register queue between the front end and the serialiser.
// ----------------------------------------------------------------------------
module mrf_queue import mrf_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    always_comb begin
        o_full  = (r_count == CW'(DEPTH));
        o_empty = (r_count == '0);
        o_data  = r_mem[r_rptr];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/mrf_back.sv
// ----------------------------------------------------------------------------
// Measurement record framer back end
// Serialises one queued record into r_byte, a byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module mrf_back import mrf_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  t_rec_hdr                i_hdr,
    input  logic [MAX_SLOTS*16-1:0] i_values,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [7:0]              o_out_byte,
    output logic                    o_last,
    output logic                    o_dropped
);

    localparam int IW = $clog2(HDR_BYTES + TS_BYTES + 2 * MAX_SLOTS);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [IW-1:0] r_idx, n_idx;
    logic          r_valid, n_valid;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;
    logic          r_dropped, n_dropped;

    logic          load;
    logic [7:0]    pos;
    logic [7:0]    rel;
    logic [7:0]    half;
    logic [1:0]    tsel;
    logic [SW-1:0] ssel;
    logic [15:0]   sval;
    logic [7:0]    gen_byte;
    logic          gen_last;
    logic          gen_drop;

    always_comb begin
        load = !r_valid || !i_stall;
        pos  = 8'(r_idx);
        rel  = pos - POS_SLOT0;
        half = rel >> 1;
        ssel = half[SW-1:0];
        tsel = 2'(pos - POS_TS0);
        sval = '0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (ssel == SW'(s)) begin
                sval = i_values[16*s +: 16];
            end
        end

        gen_last = 1'b0;
        gen_drop = 1'b0;
        priority if (i_hdr.drop) begin
            gen_byte = '0;
            gen_last = 1'b1;
            gen_drop = 1'b1;
        end else if (pos == POS_TYPE) begin
            gen_byte = i_hdr.rtype;
        end else if (pos == POS_LEN) begin
            gen_byte = i_hdr.length;
        end else if (pos < POS_SLOT0) begin
            gen_byte = i_hdr.ts[8*tsel +: 8];
        end else if (pos == i_hdr.length + 8'd2) begin
            gen_byte = END_MARK;
            gen_last = 1'b1;
        end else begin
            gen_byte = rel[0] ? sval[15:8] : sval[7:0];
        end

        n_idx     = r_idx;
        n_valid   = r_valid;
        n_byte    = r_byte;
        n_last    = r_last;
        n_dropped = r_dropped;
        o_pop     = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_byte    = gen_byte;
                n_last    = gen_last;
                n_dropped = gen_drop;
                if (gen_last) begin
                    n_idx = '0;
                    o_pop = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_last    <= n_last;
        r_dropped <= n_dropped;
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;
    assign o_dropped  = r_dropped;

endmodule

### rtl/measurement_record_framer.sv
// ----------------------------------------------------------------------------
// Measurement record framer
// Turns measurement requests into a byte stream of framed records.
// ----------------------------------------------------------------------------
// Input channel: one request per accepted i_valid with o_stall low; it carries
// a timestamp, four converter samples, the port pins and the free space.
// Output channel: one byte per accepted o_valid with i_stall low; o_last marks
// the final byte of a request, o_dropped the single byte of a skipped record.
// A record is 7 + 2 * channel_count bytes (channel_count limited to
// MAX_SLOTS, so at most 23), streamed at one byte per cycle while i_stall
// is low; a dropped request yields one byte. A request is queued, then its
// bytes are registered in r_byte; it leaves the queue with its last byte.
// A two-entry queue sits between the front end and the serialiser, so
// requests are taken while an earlier record streams out. The user is to
// write configuration through i_cfg_we, i_cfg_index and i_cfg_wdata only
// while the block is idle; the block does not enforce it. Reset clears
// the configuration registers and empties the queue. When the receiver
// stalls, the output byte holds and the queue fills; once full, o_stall rises.
// ----------------------------------------------------------------------------
module measurement_record_framer import mrf_pkg::*; #(
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_timestamp_ms,
    input  logic [11:0] i_adc_sample_0,
    input  logic [11:0] i_adc_sample_1,
    input  logic [11:0] i_adc_sample_2,
    input  logic [11:0] i_adc_sample_3,
    input  logic [7:0]  i_port_pins,
    input  logic [6:0]  i_free_space,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_dropped
);

    localparam int VW = MAX_SLOTS * 16;
    localparam int QW = $bits(t_rec_hdr) + VW;

    logic [3:0]  r_channel_count;
    logic [23:0] r_channel_map;
    logic [7:0]  r_record_type;

    t_rec_hdr          f_hdr, q_hdr;
    logic [VW-1:0]     f_values, q_values;
    logic [QW-1:0]     q_out;
    logic              q_full, q_empty, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= '0;
            r_channel_map   <= '0;
            r_record_type   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_wdata[3:0];
                REG_CHANNEL_MAP:   r_channel_map   <= i_cfg_wdata;
                REG_RECORD_TYPE:   r_record_type   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    mrf_front #(
        .MAX_SLOTS    (MAX_SLOTS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_channel_count (r_channel_count),
        .i_channel_map   (r_channel_map),
        .i_record_type   (r_record_type),
        .i_timestamp_ms  (i_timestamp_ms),
        .i_adc_sample_0  (i_adc_sample_0),
        .i_adc_sample_1  (i_adc_sample_1),
        .i_adc_sample_2  (i_adc_sample_2),
        .i_adc_sample_3  (i_adc_sample_3),
        .i_port_pins     (i_port_pins),
        .i_free_space    (i_free_space),
        .o_hdr           (f_hdr),
        .o_values        (f_values)
    );

    mrf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  ({f_hdr, f_values}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign q_hdr    = q_out[QW-1:VW];
    assign q_values = q_out[VW-1:0];
    assign o_stall  = q_full;

    mrf_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_hdr      (q_hdr),
        .i_values   (q_values),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_dropped  (o_dropped)
    );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Measurement record framer testbench
// Drives measurement requests under several register settings and predicts
// the framed byte stream of each request: the full record when it fits in
// the free space, a single dropped byte when it does not. Both channels idle
// in random bursts, and one phase holds the receiver off long enough to
// back the block up. Every accepted byte is checked against the prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import mrf_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [31:0]      ts;
        logic [3:0][11:0] adc;
        logic [7:0]       pins;
        logic [6:0]       space;
    } t_measurement;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       dropped;
    } t_record_byte;

    class record_stream_board;
        logic [3:0]   channel_count;
        logic [23:0]  channel_map;
        logic [7:0]   record_type;
        t_record_byte expected_bytes[$];
        int unsigned  errors;

        function new();
            channel_count = '0;
            channel_map   = '0;
            record_type   = '0;
            errors        = 0;
        endfunction

        function void configure(logic [1:0] index, logic [23:0] value);
            case (index)
                REG_CHANNEL_COUNT: channel_count = value[3:0];
                REG_CHANNEL_MAP:   channel_map   = value;
                REG_RECORD_TYPE:   record_type   = value[7:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] data, logic last, logic dropped);
            t_record_byte b;
            b.data    = data;
            b.last    = last;
            b.dropped = dropped;
            expected_bytes.push_back(b);
        endfunction

        function void take_request(t_measurement m);
            int unsigned slots;
            int unsigned space;
            int unsigned content;
            logic [2:0]  src;
            logic [15:0] value;
            slots   = (channel_count > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : channel_count;
            space   = (m.space > DEF_BUFFER_BYTES) ? DEF_BUFFER_BYTES : m.space;
            content = TS_BYTES + 2 * slots;
            if (space < content + HDR_BYTES) begin
                push_byte(8'h00, 1'b1, 1'b1);
                return;
            end
            push_byte(record_type, 1'b0, 1'b0);
            push_byte(content[7:0], 1'b0, 1'b0);
            for (int i = 0; i < TS_BYTES; i++)
                push_byte(m.ts[8*i +: 8], 1'b0, 1'b0);
            for (int s = 0; s < slots; s++) begin
                src = channel_map[3*s +: 3];
                case (src)
                    SRC_ADC0, SRC_ADC1, SRC_ADC2, SRC_ADC3: value = {4'h0, m.adc[src[1:0]]};
                    SRC_PINS: value = {12'h000, m.pins[4:3], m.pins[1:0]};
                    default:  value = FILL_VALUE;
                endcase
                value[15:12] = value[15:12] | m.ts[3:0];
                push_byte(value[7:0], 1'b0, 1'b0);
                push_byte(value[15:8], 1'b0, 1'b0);
            end
            push_byte(END_MARK, 1'b1, 1'b0);
        endfunction

        function void check_byte(logic [7:0] data, logic last, logic dropped);
            t_record_byte want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte: expected none, actual %02h last %0b dropped %0b",
                         $time, data, last, dropped);
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data) begin
                errors++;
                $display("%0t: out_byte: expected %02h, actual %02h", $time, want.data, data);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last: expected %0b, actual %0b", $time, want.last, last);
            end
            if (dropped !== want.dropped) begin
                errors++;
                $display("%0t: dropped: expected %0b, actual %0b", $time, want.dropped, dropped);
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_timestamp_ms;
    logic [11:0] i_adc_sample_0;
    logic [11:0] i_adc_sample_1;
    logic [11:0] i_adc_sample_2;
    logic [11:0] i_adc_sample_3;
    logic [7:0]  i_port_pins;
    logic [6:0]  i_free_space;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_dropped;

    record_stream_board board;
    bit                 quiet       = 1'b0;
    int                 hold_cycles = 0;

    measurement_record_framer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_timestamp_ms (i_timestamp_ms),
        .i_adc_sample_0 (i_adc_sample_0),
        .i_adc_sample_1 (i_adc_sample_1),
        .i_adc_sample_2 (i_adc_sample_2),
        .i_adc_sample_3 (i_adc_sample_3),
        .i_port_pins    (i_port_pins),
        .i_free_space   (i_free_space),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last),
        .o_dropped      (o_dropped)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin : stall_gen
        int run;
        run = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if (run > 0) begin
                run--;
            end else begin
                i_stall <= ($urandom_range(0, 2) == 0);
                run = $urandom_range(1, 12) - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_byte(o_out_byte, o_last, o_dropped);
    end

    initial begin
        #5_000_000;
        $display("measurement_record_framer: mismatch");
        $finish;
    end

    function automatic t_measurement mk_meas(logic [31:0] ts, logic [11:0] a0, logic [11:0] a1,
                                             logic [11:0] a2, logic [11:0] a3,
                                             logic [7:0] pins, logic [6:0] space);
        t_measurement m;
        m.ts     = ts;
        m.adc[0] = a0;
        m.adc[1] = a1;
        m.adc[2] = a2;
        m.adc[3] = a3;
        m.pins   = pins;
        m.space  = space;
        return m;
    endfunction

    task automatic write_reg(logic [1:0] index, logic [23:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        board.configure(index, value);
        @(posedge i_clk);
    endtask

    task automatic write_settings(logic [3:0] count, logic [23:0] map, logic [7:0] rtype);
        logic [23:0] value;
        value      = 24'($urandom);
        value[3:0] = count;
        write_reg(REG_CHANNEL_COUNT, value);
        write_reg(REG_CHANNEL_MAP, map);
        value      = 24'($urandom);
        value[7:0] = rtype;
        write_reg(REG_RECORD_TYPE, value);
        write_reg(REG_SPARE, 24'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(t_measurement m);
        i_valid        <= 1'b1;
        i_timestamp_ms <= m.ts;
        i_adc_sample_0 <= m.adc[0];
        i_adc_sample_1 <= m.adc[1];
        i_adc_sample_2 <= m.adc[2];
        i_adc_sample_3 <= m.adc[3];
        i_port_pins    <= m.pins;
        i_free_space   <= m.space;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.take_request(m);
    endtask

    task automatic close_phase();
        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_phase(int unsigned n, logic [3:0] count, bit dense);
        t_measurement m;
        int unsigned  total;
        total = HDR_BYTES + TS_BYTES + 2 * ((count > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : count);
        for (int i = 0; i < n; i++) begin
            m.ts     = $urandom;
            m.adc[0] = 12'($urandom_range(0, 4095));
            m.adc[1] = 12'($urandom_range(0, 4095));
            m.adc[2] = 12'($urandom_range(0, 4095));
            m.adc[3] = 12'($urandom_range(0, 4095));
            m.pins   = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 6) == 0)
                m.space = 7'($urandom_range(0, total - 1));
            else
                m.space = 7'($urandom_range(total, 127));
            send_request(m);
            if (!dense && !quiet && $urandom_range(0, 2) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        logic [3:0]  count;
        logic [23:0] map;
        logic [7:0]  rtype;
        board = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_CHANNEL_COUNT;
        i_cfg_wdata    <= '0;
        i_valid        <= 1'b0;
        i_timestamp_ms <= '0;
        i_adc_sample_0 <= '0;
        i_adc_sample_1 <= '0;
        i_adc_sample_2 <= '0;
        i_adc_sample_3 <= '0;
        i_port_pins    <= '0;
        i_free_space   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty record: header, timestamp and end mark only
        write_settings(4'd0, 24'h000000, 8'h00);
        send_request(mk_meas(32'h0000_0000, 12'h000, 12'h000, 12'h000, 12'h000, 8'h00, 7'd0));
        send_request(mk_meas(32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 7'd6));
        send_request(mk_meas(32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 7'd7));
        send_request(mk_meas(32'h0000_0000, 12'h000, 12'h000, 12'h000, 12'h000, 8'h00, 7'd127));
        close_phase();

        // full record, slot k takes source code k
        write_settings(4'd8, 24'hFAC688, 8'hFF);
        send_request(mk_meas(32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 7'd23));
        send_request(mk_meas(32'h0000_0000, 12'h000, 12'h000, 12'h000, 12'h000, 8'h00, 7'd22));
        send_request(mk_meas(32'h0000_0000, 12'h000, 12'h000, 12'h000, 12'h000, 8'h00, 7'd64));
        send_request(mk_meas(32'h1234_5670, 12'h123, 12'h456, 12'h789, 12'hABC, 8'h1B, 7'd127));
        send_request(mk_meas(32'hA5A5_A5A5, 12'hA5A, 12'h5A5, 12'hF0F, 12'h0F0, 8'hE4, 7'd65));
        send_request(mk_meas(32'h5A5A_5A5A, 12'h5A5, 12'hA5A, 12'h0F0, 12'hF0F, 8'h24, 7'd100));
        close_phase();

        // slot count above the limit
        write_settings(4'd15, 24'h05397F, 8'h5A);
        send_request(mk_meas(32'h8000_000F, 12'h800, 12'h001, 12'h7FF, 12'hFFE, 8'h18, 7'd22));
        send_request(mk_meas(32'h8000_000F, 12'h800, 12'h001, 12'h7FF, 12'hFFE, 8'h18, 7'd23));
        send_request(mk_meas(32'h7FFF_FFF0, 12'h001, 12'h800, 12'hFFE, 12'h7FF, 8'h03, 7'd64));
        close_phase();

        for (int k = 0; k < 10; k++) begin
            count = (k == 0) ? 4'd0 : (k == 8) ? 4'd8 : (k == 9) ? 4'd15 :
                    4'($urandom_range(0, 15));
            map   = (k == 1) ? 24'h000000 : (k == 2) ? 24'hFFFFFF : 24'($urandom);
            rtype = (k == 0) ? 8'h00 : (k == 9) ? 8'hFF : 8'($urandom_range(0, 255));
            quiet = (k >= 8);
            write_settings(count, map, rtype);
            if (k == 3)
                hold_cycles = 300;
            random_phase(15, count, k == 3);
            close_phase();
        end

        if (board.errors == 0 && board.pending() == 0)
            $display("measurement_record_framer: match");
        else
            $display("measurement_record_framer: mismatch");
        $finish;
    end

endmodule
